FILE: hdl/scl_pkg.sv
package scl_pkg;

    // Result list depth: one input item yields at most this many results.
    localparam int MAX_RES = 8;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    typedef enum logic [3:0] {
        K_BYTE   = 4'd0,
        K_WEND   = 4'd1,
        K_PIPE   = 4'd2,
        K_OR     = 4'd3,
        K_AND    = 4'd4,
        K_SEMI   = 4'd5,
        K_IN     = 4'd6,
        K_OUT    = 4'd7,
        K_APPEND = 4'd8,
        K_ERR    = 4'd9,
        K_ERRAPP = 4'd10,
        K_LINE   = 4'd11
    } kind_t;

    typedef enum logic [2:0] {
        M_PLAIN = 3'd0,
        M_ESC   = 3'd1,
        M_SQ    = 3'd2,
        M_DQ    = 3'd3,
        M_DQESC = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        P_NONE = 3'd0,
        P_PIPE = 3'd1,
        P_AMP  = 3'd2,
        P_OUT  = 3'd3,
        P_ERR  = 3'd4
    } pend_t;

    typedef struct packed {
        mode_t       mode;
        pend_t       pend;
        logic [7:0]  held_byte;
        logic [1:0]  wlen;
        logic        held_two;
        logic        comment;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode:      M_PLAIN,
        pend:      P_NONE,
        held_byte: 8'd0,
        wlen:      2'd0,
        held_two:  1'b0,
        comment:   1'b0
    };

    // Results caused by one item, in order; count of them in count.
    typedef struct packed {
        kind_t [MAX_RES-1:0]      kinds;
        logic  [MAX_RES-1:0][7:0] bytes;
        logic  [CNT_W-1:0]        count;
    } res_list_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_TWO    = 8'h32;

endpackage

FILE: hdl/scl_step.sv
module scl_step (
    input  scl_pkg::lex_state_t state_i,
    input  logic [7:0]          ch_i,
    input  logic                is_end_i,
    output scl_pkg::lex_state_t state_o,
    output scl_pkg::res_list_t  list_o
);

    typedef struct packed {
        scl_pkg::lex_state_t st;
        scl_pkg::res_list_t  list;
        logic                consumed;
    } work_t;

    // Append one result; results beyond the list depth are dropped.
    function automatic work_t emit(work_t w, scl_pkg::kind_t k, logic [7:0] b);
        work_t r;
        r = w;
        if (r.list.count < scl_pkg::CNT_W'(scl_pkg::MAX_RES)) begin
            r.list.kinds[r.list.count[$clog2(scl_pkg::MAX_RES)-1:0]] = k;
            r.list.bytes[r.list.count[$clog2(scl_pkg::MAX_RES)-1:0]] =
                (k == scl_pkg::K_BYTE) ? b : 8'd0;
            r.list.count = r.list.count + scl_pkg::CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t flush_two(work_t w);
        work_t r;
        r = w;
        if (r.st.held_two) begin
            r = emit(r, scl_pkg::K_BYTE, scl_pkg::CH_TWO);
            r = emit(r, scl_pkg::K_WEND, 8'd0);
            r.st.held_two = 1'b0;
        end
        return r;
    endfunction

    function automatic work_t emit_op(work_t w, scl_pkg::kind_t k);
        work_t r;
        r = flush_two(w);
        r = emit(r, k, 8'd0);
        return r;
    endfunction

    // The first byte of a word is held until the second arrives or the word ends.
    function automatic work_t add_byte(work_t w, logic [7:0] b);
        work_t r;
        r = flush_two(w);
        case (r.st.wlen)
            2'd0: begin
                r.st.held_byte = b;
                r.st.wlen      = 2'd1;
            end
            2'd1: begin
                r = emit(r, scl_pkg::K_BYTE, r.st.held_byte);
                r = emit(r, scl_pkg::K_BYTE, b);
                r.st.wlen = 2'd2;
            end
            default: begin
                r = emit(r, scl_pkg::K_BYTE, b);
            end
        endcase
        return r;
    endfunction

    function automatic work_t end_word(work_t w);
        work_t r;
        r = w;
        if (r.st.wlen == 2'd1) begin
            if (r.st.held_byte == scl_pkg::CH_TWO) begin
                r.st.held_two = 1'b1;
            end else begin
                r = emit(r, scl_pkg::K_BYTE, r.st.held_byte);
                r = emit(r, scl_pkg::K_WEND, 8'd0);
            end
        end else if (r.st.wlen >= 2'd2) begin
            r = emit(r, scl_pkg::K_WEND, 8'd0);
        end
        r.st.wlen      = 2'd0;
        r.st.held_byte = 8'd0;
        return r;
    endfunction

    // Settle a waiting operator; consumed tells whether the byte completed it.
    function automatic work_t resolve(work_t w, logic have, logic [7:0] c);
        work_t r;
        r = w;
        r.st.pend  = scl_pkg::P_NONE;
        r.consumed = 1'b0;
        case (w.st.pend)
            scl_pkg::P_PIPE: begin
                if (have && c == scl_pkg::CH_PIPE) begin
                    r = emit_op(r, scl_pkg::K_OR);
                    r.consumed = 1'b1;
                end else begin
                    r = emit_op(r, scl_pkg::K_PIPE);
                end
            end
            scl_pkg::P_AMP: begin
                if (have && c == scl_pkg::CH_AMP) begin
                    r = emit_op(r, scl_pkg::K_AND);
                    r.consumed = 1'b1;
                end
            end
            scl_pkg::P_OUT: begin
                if (have && c == scl_pkg::CH_GT) begin
                    r = emit_op(r, scl_pkg::K_APPEND);
                    r.consumed = 1'b1;
                end else begin
                    r = emit_op(r, scl_pkg::K_OUT);
                end
            end
            scl_pkg::P_ERR: begin
                if (have && c == scl_pkg::CH_GT) begin
                    r = emit(r, scl_pkg::K_ERRAPP, 8'd0);
                    r.consumed = 1'b1;
                end else begin
                    r = emit(r, scl_pkg::K_ERR, 8'd0);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic work_t plain_byte(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        case (c)
            scl_pkg::CH_SPACE, scl_pkg::CH_TAB: begin
                r = end_word(r);
            end
            scl_pkg::CH_HASH: begin
                r = end_word(r);
                r.st.comment = 1'b1;
            end
            scl_pkg::CH_PIPE: begin
                r = end_word(r);
                r.st.pend = scl_pkg::P_PIPE;
            end
            scl_pkg::CH_AMP: begin
                r = end_word(r);
                r.st.pend = scl_pkg::P_AMP;
            end
            scl_pkg::CH_SEMI: begin
                r = end_word(r);
                r = emit_op(r, scl_pkg::K_SEMI);
            end
            scl_pkg::CH_LT: begin
                r = end_word(r);
                r = emit_op(r, scl_pkg::K_IN);
            end
            scl_pkg::CH_GT: begin
                r = end_word(r);
                if (r.st.held_two) begin
                    r.st.held_two = 1'b0;
                    r.st.pend     = scl_pkg::P_ERR;
                end else begin
                    r.st.pend = scl_pkg::P_OUT;
                end
            end
            scl_pkg::CH_BSLASH: r.st.mode = scl_pkg::M_ESC;
            scl_pkg::CH_SQUOTE: r.st.mode = scl_pkg::M_SQ;
            scl_pkg::CH_DQUOTE: r.st.mode = scl_pkg::M_DQ;
            default: begin
                r = add_byte(r, c);
            end
        endcase
        return r;
    endfunction

    work_t w;

    always_comb begin
        w.st       = state_i;
        w.list     = '0;
        w.consumed = 1'b0;
        if (is_end_i) begin
            w = resolve(w, 1'b0, 8'd0);
            if (w.st.mode == scl_pkg::M_ESC || w.st.mode == scl_pkg::M_DQESC) begin
                w = add_byte(w, scl_pkg::CH_BSLASH);
            end
            w = end_word(w);
            w = flush_two(w);
            w = emit(w, scl_pkg::K_LINE, 8'd0);
            w.st = scl_pkg::LEX_RESET;
        end else if (!w.st.comment) begin
            case (w.st.mode)
                scl_pkg::M_ESC: begin
                    w = add_byte(w, ch_i);
                    w.st.mode = scl_pkg::M_PLAIN;
                end
                scl_pkg::M_SQ: begin
                    if (ch_i == scl_pkg::CH_SQUOTE) begin
                        w.st.mode = scl_pkg::M_PLAIN;
                    end else begin
                        w = add_byte(w, ch_i);
                    end
                end
                scl_pkg::M_DQ: begin
                    if (ch_i == scl_pkg::CH_DQUOTE) begin
                        w.st.mode = scl_pkg::M_PLAIN;
                    end else if (ch_i == scl_pkg::CH_BSLASH) begin
                        w.st.mode = scl_pkg::M_DQESC;
                    end else begin
                        w = add_byte(w, ch_i);
                    end
                end
                scl_pkg::M_DQESC: begin
                    if (!(ch_i inside {scl_pkg::CH_DQUOTE, scl_pkg::CH_BSLASH,
                                       scl_pkg::CH_DOLLAR, scl_pkg::CH_BQUOTE})) begin
                        w = add_byte(w, scl_pkg::CH_BSLASH);
                    end
                    w = add_byte(w, ch_i);
                    w.st.mode = scl_pkg::M_DQ;
                end
                default: begin
                    w.st.mode = scl_pkg::M_PLAIN;
                    w = resolve(w, 1'b1, ch_i);
                    if (!w.consumed) begin
                        w = plain_byte(w, ch_i);
                    end
                end
            endcase
        end
    end

    assign state_o = w.st;
    assign list_o  = w.list;

endmodule

FILE: hdl/scl_outbuf.sv
module scl_outbuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_i,
    input  scl_pkg::res_list_t list_i,
    output logic               space_o,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_kind,
    output logic [7:0]         m_word_byte,
    output logic               m_last
);

    scl_pkg::kind_t [scl_pkg::MAX_RES-1:0]      kind_reg, kind_next;
    logic           [scl_pkg::MAX_RES-1:0][7:0] byte_reg, byte_next;
    logic           [scl_pkg::CNT_W-1:0]        rem_reg, rem_next;
    logic                                       pop;

    assign pop     = m_valid && m_ready;
    assign space_o = (rem_reg == '0) || (rem_reg == scl_pkg::CNT_W'(1) && m_ready);

    always_comb begin
        kind_next = kind_reg;
        byte_next = byte_reg;
        rem_next  = rem_reg;
        if (load_i) begin
            kind_next = list_i.kinds;
            byte_next = list_i.bytes;
            rem_next  = list_i.count;
        end else if (pop) begin
            for (int i = 0; i < scl_pkg::MAX_RES - 1; i++) begin
                kind_next[i] = kind_reg[i+1];
                byte_next[i] = byte_reg[i+1];
            end
            kind_next[scl_pkg::MAX_RES-1] = scl_pkg::K_BYTE;
            byte_next[scl_pkg::MAX_RES-1] = 8'd0;
            rem_next = rem_reg - scl_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    assign m_valid     = rem_reg != '0;
    assign m_last      = rem_reg == scl_pkg::CNT_W'(1);
    assign m_kind      = kind_reg[0];
    assign m_word_byte = byte_reg[0];

endmodule

FILE: hdl/shell_command_line_lexer.sv
// Command line lexer for a subset of POSIX shell syntax. Feed one byte of the
// line per item on s_ch with s_is_end low, then one item with s_is_end high to
// close the line; the block answers with word bytes, word-end markers, operator
// tokens (| || && ; < > >> 2> 2>>) and a final line-end marker on the m_ channel,
// with m_last high on the final result of each input item. An item that yields
// results shows its first result the cycle after it is accepted. Items are taken
// at one per cycle as long as each yields at most one result and m_ready stays
// high; an item with several results holds the result buffer until all are
// taken, as it sends one result per cycle while m_ready is high, and the next
// item is taken in the cycle in which the last of them is taken. Items that
// yield nothing (blanks, the first byte of a word, quotes) cause no stall of
// their own, but like every item they wait while the buffer still holds results.
module shell_command_line_lexer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_kind,
    output logic [7:0] m_word_byte,
    output logic       m_last
);

    // Lexer state: quoting mode, waiting operator, held first byte of a word,
    // word length (saturating at two), held "2" word and comment flag.
    scl_pkg::lex_state_t state_reg, state_next;
    scl_pkg::res_list_t  step_list;
    logic                accept;
    logic                load;

    assign accept = s_valid && s_ready;

    // All results of one item are formed in a single pass of combinational
    // logic and land together in the result buffer.
    scl_step u_step (
        .state_i  (state_reg),
        .ch_i     (s_ch),
        .is_end_i (s_is_end),
        .state_o  (state_next),
        .list_o   (step_list)
    );

    // Items that yield nothing only update the state and leave the buffer alone.
    assign load = accept && (step_list.count != '0);

    scl_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_i      (load),
        .list_i      (step_list),
        .space_o     (s_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_word_byte (m_word_byte),
        .m_last      (m_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scl_pkg::LEX_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // A line end puts the lexer back to its idle state.
    a_line_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_end) |=> (state_reg == scl_pkg::LEX_RESET))
        else $error("lexer state not cleared after line end");

    // Once the final result of a burst is taken, nothing follows unless a new
    // item was loaded in the same cycle.
    a_burst_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last && !load) |=> !m_valid)
        else $error("result shown after the final result of an item");

    // A line end always yields at least its line-end marker.
    a_line_end_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_is_end) |-> load)
        else $error("line end item produced no results");

    // In a comment no quoting mode or operator can still be open.
    a_comment_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.comment |-> (state_reg.mode == scl_pkg::M_PLAIN &&
                               state_reg.pend == scl_pkg::P_NONE))
        else $error("comment entered with open mode or operator");

    // A held "2" word is only kept between words.
    a_held_two_between_words: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.held_two |-> (state_reg.wlen == 2'd0))
        else $error("held two word overlaps a word in progress");

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import scl_pkg::*;

    // Run length and thresholds in items, hold and safety limits in clock cycles.
    localparam int TOTAL_ITEMS = 470;
    localparam int HOLD_AT     = 150;     // item count at which the long receiver hold starts
    localparam int DRAIN_AT    = 290;     // item count at which the sender waits for a full drain
    localparam int CALM_AT     = 400;     // from here on neither side idles
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 16;
    localparam int DRAIN_MAX   = 4000;
    localparam int CYCLE_LIMIT = 400000;

    // One expected result on the m_ side.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] wbyte;
        logic       last;
    } tok_t;

    // One row of stimulus. When nfix is nonzero the row carries its own expected
    // results (at most two) instead of taking them from the lexer model below.
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic [1:0] nfix;
        kind_t      k0;
        logic [7:0] b0;
        kind_t      k1;
        logic [7:0] b1;
    } row_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'd0;
    logic       s_is_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_kind;
    logic [7:0] m_word_byte;
    logic       m_last;

    shell_command_line_lexer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .s_is_end    (s_is_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_word_byte (m_word_byte),
        .m_last      (m_last)
    );

    // The lexer model keeps its own copy of the tokenizer state. Results of the
    // item being worked on collect in item_toks; tok_expect holds every result
    // still owed by the block, oldest first.
    lex_state_t lx = LEX_RESET;
    tok_t       item_toks[$];
    tok_t       tok_expect[$];
    row_t       dir_rows[$];

    row_t        cur_row;
    int          items_sent = 0;
    int          lines_sent = 0;
    int          toks_seen  = 0;
    int          n_err      = 0;
    int          cycles     = 0;
    bit   [15:0] kinds_hit  = '0;
    bit          calm       = 1'b0;
    bit          hold_go    = 1'b0;
    bit          hold_done  = 1'b0;
    bit          drained    = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    // Append one result; the block never produces more than MAX_RES per item.
    function automatic void put_tok(input kind_t k, input logic [7:0] b);
        tok_t t;
        if (item_toks.size() < MAX_RES) begin
            t.kind  = k;
            t.wbyte = (k == K_BYTE) ? b : 8'd0;
            t.last  = 1'b0;
            item_toks.insert(item_toks.size(), t);
        end
    endfunction

    // A finished word "2" that did not turn into a redirection goes out as a word.
    function automatic void flush_held_two();
        if (lx.held_two) begin
            put_tok(K_BYTE, CH_TWO);
            put_tok(K_WEND, 8'd0);
            lx.held_two = 1'b0;
        end
    endfunction

    function automatic void put_op(input kind_t k);
        flush_held_two();
        put_tok(k, 8'd0);
    endfunction

    // The first byte of a word is kept back until the second one arrives or the
    // word closes, so that a lone "2" can still become a stderr redirection.
    function automatic void word_char(input logic [7:0] b);
        flush_held_two();
        case (lx.wlen)
            2'd0: begin
                lx.held_byte = b;
                lx.wlen      = 2'd1;
            end
            2'd1: begin
                put_tok(K_BYTE, lx.held_byte);
                put_tok(K_BYTE, b);
                lx.wlen = 2'd2;
            end
            default: put_tok(K_BYTE, b);
        endcase
    endfunction

    function automatic void close_word();
        if (lx.wlen == 2'd1) begin
            if (lx.held_byte == CH_TWO) begin
                lx.held_two = 1'b1;
            end else begin
                put_tok(K_BYTE, lx.held_byte);
                put_tok(K_WEND, 8'd0);
            end
        end else if (lx.wlen >= 2'd2) begin
            put_tok(K_WEND, 8'd0);
        end
        lx.wlen      = 2'd0;
        lx.held_byte = 8'd0;
    endfunction

    // A one-character operator waits for the next byte to tell | from ||, & from
    // &&, > from >> and 2> from 2>>. Returns 1 when that byte completed it.
    function automatic bit settle_op(input bit have, input logic [7:0] c);
        pend_t p;
        p = lx.pend;
        lx.pend = P_NONE;
        case (p)
            P_PIPE: begin
                if (have && c == CH_PIPE) begin
                    put_op(K_OR);
                    return 1'b1;
                end
                put_op(K_PIPE);
            end
            P_AMP: begin
                // A lone ampersand produces nothing.
                if (have && c == CH_AMP) begin
                    put_op(K_AND);
                    return 1'b1;
                end
            end
            P_OUT: begin
                if (have && c == CH_GT) begin
                    put_op(K_APPEND);
                    return 1'b1;
                end
                put_op(K_OUT);
            end
            P_ERR: begin
                if (have && c == CH_GT) begin
                    put_tok(K_ERRAPP, 8'd0);
                    return 1'b1;
                end
                put_tok(K_ERR, 8'd0);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void unquoted_char(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB: close_word();
            CH_HASH: begin
                close_word();
                lx.comment = 1'b1;
            end
            CH_PIPE: begin
                close_word();
                lx.pend = P_PIPE;
            end
            CH_AMP: begin
                close_word();
                lx.pend = P_AMP;
            end
            CH_SEMI: begin
                close_word();
                put_op(K_SEMI);
            end
            CH_LT: begin
                close_word();
                put_op(K_IN);
            end
            CH_GT: begin
                close_word();
                if (lx.held_two) begin
                    lx.held_two = 1'b0;
                    lx.pend     = P_ERR;
                end else begin
                    lx.pend = P_OUT;
                end
            end
            CH_BSLASH: lx.mode = M_ESC;
            CH_SQUOTE: lx.mode = M_SQ;
            CH_DQUOTE: lx.mode = M_DQ;
            default:   word_char(c);
        endcase
    endfunction

    // Work out every result caused by one accepted item, in order, with the
    // last flag on the final one.
    function automatic void lex_item(input logic [7:0] c, input logic eol);
        tok_t t;
        item_toks.delete();
        if (eol) begin
            void'(settle_op(1'b0, 8'd0));
            // A backslash left hanging at the end of the line is taken literally.
            if (lx.mode == M_ESC || lx.mode == M_DQESC)
                word_char(CH_BSLASH);
            close_word();
            flush_held_two();
            put_tok(K_LINE, 8'd0);
            lx = LEX_RESET;
        end else if (!lx.comment) begin
            case (lx.mode)
                M_ESC: begin
                    word_char(c);
                    lx.mode = M_PLAIN;
                end
                M_SQ: begin
                    if (c == CH_SQUOTE)
                        lx.mode = M_PLAIN;
                    else
                        word_char(c);
                end
                M_DQ: begin
                    if (c == CH_DQUOTE)
                        lx.mode = M_PLAIN;
                    else if (c == CH_BSLASH)
                        lx.mode = M_DQESC;
                    else
                        word_char(c);
                end
                M_DQESC: begin
                    // Inside double quotes only four bytes can be escaped; before
                    // any other byte the backslash stays in the word.
                    if (c != CH_DQUOTE && c != CH_BSLASH && c != CH_DOLLAR && c != CH_BQUOTE)
                        word_char(CH_BSLASH);
                    word_char(c);
                    lx.mode = M_DQ;
                end
                default: begin
                    lx.mode = M_PLAIN;
                    if (!settle_op(1'b1, c))
                        unquoted_char(c);
                end
            endcase
        end
        if (item_toks.size() != 0) begin
            t = item_toks[item_toks.size() - 1];
            t.last = 1'b1;
            item_toks[item_toks.size() - 1] = t;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where the inputs have
    // been stable since the falling edge and the outputs still show the values
    // of the previous cycle. Results are checked before the item accepted at the
    // same edge is modelled; its results only show once they sit in the result buffer.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        tok_t t;
        tok_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                toks_seen++;
                kinds_hit[m_kind] = 1'b1;
                if (tok_expect.size() == 0) begin
                    $error("unexpected result: kind %0d, word_byte 0x%02h, last %0b",
                           m_kind, m_word_byte, m_last);
                    n_err++;
                end else begin
                    want = tok_expect.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, m_kind);
                        n_err++;
                    end
                    if (m_word_byte !== want.wbyte) begin
                        $error("word_byte: expected 0x%02h, got 0x%02h",
                               want.wbyte, m_word_byte);
                        n_err++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        n_err++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                // The model always runs so that its state follows the line; rows
                // that carry their own results use those in its place.
                lex_item(s_ch, s_is_end);
                if (cur_row.nfix != 2'd0) begin
                    t.kind  = cur_row.k0;
                    t.wbyte = cur_row.b0;
                    t.last  = (cur_row.nfix == 2'd1);
                    tok_expect.insert(tok_expect.size(), t);
                    if (cur_row.nfix == 2'd2) begin
                        t.kind  = cur_row.k1;
                        t.wbyte = cur_row.b1;
                        t.last  = 1'b1;
                        tok_expect.insert(tok_expect.size(), t);
                    end
                end else begin
                    foreach (item_toks[i])
                        tok_expect.insert(tok_expect.size(), item_toks[i]);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycles,
                     tok_expect.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold while the sender keeps offering
    // items so that the result buffer fills and s_ready drops, and no stalls at
    // all once the run has calmed down.
    // ------------------------------------------------------------------
    initial begin : receiver
        forever begin
            @(negedge aclk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                m_ready   = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    function automatic row_t plain_row(input logic [7:0] c, input logic eol);
        row_t r;
        r      = '0;
        r.ch   = c;
        r.eol  = eol;
        r.k0   = K_BYTE;
        r.k1   = K_BYTE;
        return r;
    endfunction

    function automatic row_t fixed_row(input logic [7:0] c, input logic eol,
                                       input logic [1:0] n, input kind_t k0,
                                       input logic [7:0] b0, input kind_t k1,
                                       input logic [7:0] b1);
        row_t r;
        r      = plain_row(c, eol);
        r.nfix = n;
        r.k0   = k0;
        r.b0   = b0;
        r.k1   = k1;
        r.b1   = b1;
        return r;
    endfunction

    function automatic void add_row(input row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // Bytes for well-formed lines: mostly word characters, with operators,
    // quotes, escapes and the digit 2 often enough to build redirections.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: return 8'h61 + 8'($urandom_range(0, 25));
            5, 6:  return CH_TWO;
            7:     return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
            8:     return CH_PIPE;
            9:     return CH_AMP;
            10:    return CH_GT;
            11:    return ($urandom_range(0, 1) != 0) ? CH_LT : CH_SEMI;
            12:    return ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
            13:    return CH_BSLASH;
            14: begin
                case ($urandom_range(0, 2))
                    0:       return CH_DOLLAR;
                    1:       return CH_BQUOTE;
                    default: return CH_HASH;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item, after an optional idle burst, and hold it until accepted.
    // Called at a falling edge and returns at a falling edge.
    task automatic send_item(input row_t r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        cur_row  = r;
        s_ch     = r.ch;
        s_is_end = r.eol;
        s_valid  = 1'b1;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (r.eol)
            lines_sent++;
        @(negedge aclk);
    endtask

    initial begin : stimulus
        bit   noise;
        int   len;
        int   drain;

        cur_row = plain_row(8'd0, 1'b0);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed lines. Each comment says what the row exercises.
        add_row(fixed_row(8'h00, 1'b1, 2'd1, K_LINE, 8'h00, K_BYTE, 8'h00)); // empty line
        add_row(plain_row(8'h00, 1'b0));                  // lowest byte, held back
        add_row(fixed_row(8'hFF, 1'b0, 2'd2, K_BYTE, 8'h00, K_BYTE, 8'hFF));
        add_row(plain_row(CH_PIPE, 1'b0));                // word end, pipe waits
        add_row(plain_row(CH_PIPE, 1'b0));                // ||
        add_row(plain_row(CH_AMP, 1'b0));
        add_row(plain_row(CH_AMP, 1'b0));                 // &&
        add_row(plain_row(CH_TWO, 1'b0));
        add_row(plain_row(CH_AMP, 1'b0));                 // "2" held over a lone &
        add_row(plain_row(CH_GT, 1'b0));                  // becomes 2>
        add_row(fixed_row(CH_GT, 1'b0, 2'd1, K_ERRAPP, 8'h00, K_BYTE, 8'h00));
        add_row(plain_row(CH_TWO, 1'b0));
        add_row(plain_row(CH_TAB, 1'b0));                 // "2" held over a blank
        add_row(plain_row(CH_GT, 1'b0));
        add_row(fixed_row(CH_SEMI, 1'b0, 2'd2, K_ERR, 8'h00, K_SEMI, 8'h00));
        add_row(plain_row(CH_BSLASH, 1'b0));              // escaped hash
        add_row(plain_row(CH_HASH, 1'b0));
        add_row(plain_row(CH_DQUOTE, 1'b0));
        add_row(plain_row(CH_BSLASH, 1'b0));              // \$ inside double quotes
        add_row(plain_row(CH_DOLLAR, 1'b0));
        add_row(plain_row(CH_BSLASH, 1'b0));              // \n keeps its backslash
        add_row(plain_row(8'h6E, 1'b0));
        add_row(plain_row(CH_DQUOTE, 1'b0));
        add_row(plain_row(CH_LT, 1'b0));
        add_row(plain_row(CH_SQUOTE, 1'b0));              // unclosed single quote
        add_row(plain_row(CH_GT, 1'b0));
        add_row(plain_row(8'hA5, 1'b1));
        add_row(plain_row(CH_TWO, 1'b0));
        add_row(plain_row(CH_SPACE, 1'b0));
        add_row(plain_row(8'h78, 1'b0));                  // "2" flushed before a word
        add_row(plain_row(CH_GT, 1'b0));
        add_row(plain_row(CH_HASH, 1'b0));                // > then a comment
        add_row(plain_row(8'h5A, 1'b1));
        add_row(plain_row(CH_BSLASH, 1'b0));              // trailing backslash
        add_row(plain_row(8'hFF, 1'b1));
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // Random lines. Most are built from shell-like characters so that quotes,
        // escapes and redirections nest in many ways; about one in five is raw
        // noise over the full byte range. Every line ends with an end item whose
        // ignored byte is random too.
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= HOLD_AT)
                hold_go = 1'b1;
            if (items_sent >= DRAIN_AT && !drained) begin
                // Let the block run dry before carrying on.
                drained = 1'b1;
                s_valid = 1'b0;
                while (tok_expect.size() != 0)
                    @(negedge aclk);
            end
            if (items_sent >= CALM_AT)
                calm = 1'b1;
            noise = ($urandom_range(0, 4) == 0);
            len   = noise ? $urandom_range(1, 8) : $urandom_range(0, 14);
            repeat (len) begin
                if (noise)
                    send_item(plain_row(8'($urandom_range(0, 255)), 1'b0));
                else
                    send_item(plain_row(pick_char(), 1'b0));
            end
            send_item(plain_row(8'($urandom_range(0, 255)), 1'b1));
        end
        s_valid = 1'b0;

        // Wait for the last results, then watch a little longer for strays.
        drain = 0;
        while (tok_expect.size() != 0 && drain < DRAIN_MAX) begin
            @(negedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (tok_expect.size() != 0) begin
            $error("%0d results never arrived", tok_expect.size());
            n_err++;
        end

        $display("Sent %0d items in %0d lines; checked %0d results covering kinds %b.",
                 items_sent, lines_sent, toks_seen, kinds_hit[11:0]);
        $display("Included a %0d-cycle receiver hold and a full drain pause.", LONG_HOLD);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
